>>> src/chassis_current_power_limiter_assert.svh
// Assertion macros for the chassis current power limiter
`ifndef CHASSIS_CURRENT_POWER_LIMITER_ASSERT_SVH
`define CHASSIS_CURRENT_POWER_LIMITER_ASSERT_SVH

// same-cycle implication, off during reset
`define CLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after reset
`define CLP_ASSERT_AFTER_RESET(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

>>> src/clp_pkg.sv
// Shared types, constants and helpers of the chassis current power limiter
package clp_pkg;

  localparam int WHEEL_COUNT_DEF = 4;
  localparam int NUM_MOTORS      = 8;
  localparam int IDX_W           = 3;
  localparam int SET_W           = 16;
  localparam int MAG_W           = 17;
  localparam int LIM_W           = 17;
  localparam int BUF_W           = 12;
  localparam int WSUM_W          = 18;
  localparam int MSUM_W          = 16;
  localparam int THR_W           = 18;
  localparam int DVD_W           = 34;
  localparam int DVS_W           = 18;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 18;
  localparam int S_TDATA_W       = 56;
  localparam int M_TDATA_W       = 24;
  localparam int M_TUSER_W       = 2;

  localparam logic [1:0] MODE_OFFLINE  = 2'd0;
  localparam logic [1:0] MODE_ENGINEER = 2'd1;
  localparam logic [1:0] MODE_OTHER    = 2'd2;

  localparam logic KIND_REFEREE = 1'b0;
  localparam logic KIND_MOTOR   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINEER_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_BUFFER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BUFFER     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLOAD_THR   = 3'd6;

  localparam logic [LIM_W-1:0]  RST_OFFLINE_LIMIT  = 17'd8000;
  localparam logic [LIM_W-1:0]  RST_ENGINEER_LIMIT = 17'd64000;
  localparam logic [LIM_W-1:0]  RST_BUFFER_LIMIT   = 17'd16000;
  localparam logic [LIM_W-1:0]  RST_POWER_LIMIT    = 17'd20000;
  localparam logic [BUF_W-1:0]  RST_WARNING_BUFFER = 12'd960;
  localparam logic [BUF_W-1:0]  RST_MIN_BUFFER     = 12'd80;
  localparam logic [THR_W-1:0]  RST_OVERLOAD_THR   = 18'd3072;

  localparam logic [LIM_W-1:0]  LIM_MAX  = '1;
  localparam logic [WSUM_W-1:0] WSUM_MAX = '1;
  localparam logic [MSUM_W-1:0] MSUM_MAX = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FLAGS,
    ST_RD,
    ST_MAG,
    ST_FIN,
    ST_OUT
  } clp_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } clp_div_stat_t;

  // magnitude of a signed 16-bit value, -32768 gives 32768
  function automatic logic [MAG_W-1:0] mag16(input logic [SET_W-1:0] x);
    logic [MAG_W-1:0] ext;
    ext = {x[SET_W-1], x};
    return x[SET_W-1] ? (MAG_W'(0) - ext) : ext;
  endfunction

endpackage

>>> src/clp_ram.sv
// Generic single-write, single-read RAM with registered read data
module clp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/clp_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module clp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [clp_pkg::DVD_W-1:0]    dividend,
  input  logic [clp_pkg::DVS_W-1:0]    divisor,
  output logic [clp_pkg::DVD_W-1:0]    quotient,
  output clp_pkg::clp_div_stat_t       stat
);

  localparam int CNT_W = $clog2(clp_pkg::DVD_W + 1);

  logic [clp_pkg::DVS_W-1:0] rem;
  logic [clp_pkg::DVS_W-1:0] dvs;
  logic [clp_pkg::DVD_W-1:0] quo;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [clp_pkg::DVS_W:0]   trial;
  logic                      fits;

  assign trial = {rem, quo[clp_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(clp_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? clp_pkg::DVS_W'(trial - {1'b0, dvs}) : trial[clp_pkg::DVS_W-1:0];
      quo <= {quo[clp_pkg::DVD_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> src/chassis_current_power_limiter.sv
// Top level of the chassis current power limiter
//
// Input stream s_*: one transaction per item. s_tuser is the kind (0 referee,
// 1 motor). A referee transaction latches mode and energy buffer. Motor
// transactions store the setpoint in an 8-entry RAM and update the measured
// current sum, and for drive wheels also the wheel sum. The motor transaction with
// s_tlast set closes the set and starts the limiter sequence.
// Sequence: pick the limit; in the other mode with the buffer below the warning
// level, a 17x17 multiply and then the serial divider set it. Then per motor
// read the setpoint and take its magnitude, with a multiply and a divide for each
// drive wheel when the set is scaled, then apply the overload cut and the sign.
// Output stream m_*: eight transactions in index order, the last with m_tlast.
// A full output register waits for m_tready; the sequence stalls behind it.
// s_tready is high only while no set is being sequenced.
// Config: cfg_valid/cfg_ready write channel, always ready; the user must write it only while idle (not enforced).
// Reset (rst, synchronous): registers to their defaults, mode offline, buffer
// and sums zero, output empty. The setpoint RAM is not cleared.
module chassis_current_power_limiter #(
  parameter int WHEEL_COUNT = clp_pkg::WHEEL_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // referee_mode[1:0], power_buffer[13:2], motor_index[16:14],
  // current_set[32:17], given_current[48:33], zero pad
  input  logic [clp_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  // kind
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_index[2:0], limited_set[18:3], zero pad
  output logic [clp_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                              m_tlast,
  // scaled[0], overload[1]
  output logic [clp_pkg::M_TUSER_W-1:0]     m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [clp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [clp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int W_IDX = clp_pkg::IDX_W;

  clp_pkg::clp_state_t state, state_next;

  logic [clp_pkg::LIM_W-1:0]  offline_limit, engineer_limit;
  logic [clp_pkg::LIM_W-1:0]  buffer_current_limit, power_current_limit;
  logic [clp_pkg::BUF_W-1:0]  warning_buffer, min_buffer;
  logic [clp_pkg::THR_W-1:0]  overload_threshold;

  logic [1:0]                  mode_reg;
  logic [clp_pkg::BUF_W-1:0]   buffer_reg;
  logic [clp_pkg::WSUM_W-1:0]  wheel_abs_sum;
  logic [clp_pkg::MSUM_W-1:0]  measured_sum;
  logic [clp_pkg::LIM_W-1:0]   current_limit;

  logic                        lim_phase;
  logic                        scaled;
  logic                        over;
  logic [W_IDX-1:0]            k;
  logic [clp_pkg::MAG_W-1:0]   mag;
  logic                        neg;
  logic [2*clp_pkg::MAG_W-1:0] prod;
  logic [clp_pkg::SET_W-1:0]   res;

  logic [1:0]                  in_mode;
  logic [clp_pkg::BUF_W-1:0]   in_buffer;
  logic [W_IDX-1:0]            in_index;
  logic [clp_pkg::SET_W-1:0]   in_set;
  logic [clp_pkg::SET_W-1:0]   in_meas;

  logic                        s_acc;
  logic                        motor_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        ram_re;
  logic                        div_start;
  logic [clp_pkg::SET_W-1:0]   ram_rdata;
  logic [clp_pkg::DVD_W-1:0]   div_q;
  clp_pkg::clp_div_stat_t      div_stat;

  logic                        in_wheel;
  logic                        k_wheel;
  logic                        low_buffer;
  logic [clp_pkg::BUF_W-1:0]   eff_buffer;
  logic [clp_pkg::LIM_W:0]     healthy_sum;
  logic [clp_pkg::LIM_W-1:0]   direct_limit;
  logic [clp_pkg::MAG_W-1:0]   mul_a, mul_b;
  logic [clp_pkg::DVS_W-1:0]   div_divisor;
  logic [clp_pkg::WSUM_W:0]    wsum_add;
  logic [clp_pkg::MSUM_W:0]    msum_add;
  logic [clp_pkg::MAG_W-1:0]   in_set_mag, in_meas_mag;
  logic [clp_pkg::MAG_W-1:0]   cut_mag;
  logic [clp_pkg::MAG_W-1:0]   signed_mag;

  assign in_mode   = s_tdata[1:0];
  assign in_buffer = s_tdata[13:2];
  assign in_index  = s_tdata[16:14];
  assign in_set    = s_tdata[32:17];
  assign in_meas   = s_tdata[48:33];

  assign s_acc     = s_tvalid && s_tready;
  assign motor_acc = s_acc && (s_tuser == clp_pkg::KIND_MOTOR);
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign in_wheel = {1'b0, in_index} < (W_IDX + 1)'(WHEEL_COUNT);
  assign k_wheel  = {1'b0, k} < (W_IDX + 1)'(WHEEL_COUNT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offline_limit        <= clp_pkg::RST_OFFLINE_LIMIT;
      engineer_limit       <= clp_pkg::RST_ENGINEER_LIMIT;
      buffer_current_limit <= clp_pkg::RST_BUFFER_LIMIT;
      power_current_limit  <= clp_pkg::RST_POWER_LIMIT;
      warning_buffer       <= clp_pkg::RST_WARNING_BUFFER;
      min_buffer           <= clp_pkg::RST_MIN_BUFFER;
      overload_threshold   <= clp_pkg::RST_OVERLOAD_THR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clp_pkg::CFG_OFFLINE_LIMIT:  offline_limit        <= cfg_data[clp_pkg::LIM_W-1:0];
        clp_pkg::CFG_ENGINEER_LIMIT: engineer_limit       <= cfg_data[clp_pkg::LIM_W-1:0];
        clp_pkg::CFG_BUFFER_LIMIT:   buffer_current_limit <= cfg_data[clp_pkg::LIM_W-1:0];
        clp_pkg::CFG_POWER_LIMIT:    power_current_limit  <= cfg_data[clp_pkg::LIM_W-1:0];
        clp_pkg::CFG_WARNING_BUFFER: warning_buffer       <= cfg_data[clp_pkg::BUF_W-1:0];
        clp_pkg::CFG_MIN_BUFFER:     min_buffer           <= cfg_data[clp_pkg::BUF_W-1:0];
        clp_pkg::CFG_OVERLOAD_THR:   overload_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // limit selection
  assign low_buffer  = (mode_reg == clp_pkg::MODE_OTHER) && (buffer_reg < warning_buffer);
  assign eff_buffer  = (buffer_reg > min_buffer) ? buffer_reg : min_buffer;
  assign healthy_sum = {1'b0, buffer_current_limit} + {1'b0, power_current_limit};

  always_comb begin
    case (mode_reg)
      clp_pkg::MODE_ENGINEER: direct_limit = engineer_limit;
      clp_pkg::MODE_OTHER:
        direct_limit = healthy_sum[clp_pkg::LIM_W] ? clp_pkg::LIM_MAX
                                                   : healthy_sum[clp_pkg::LIM_W-1:0];
      default: direct_limit = offline_limit;
    endcase
  end

  // accumulation on motor transactions
  assign in_set_mag  = clp_pkg::mag16(in_set);
  assign in_meas_mag = clp_pkg::mag16(in_meas);
  assign wsum_add    = {1'b0, wheel_abs_sum} + (clp_pkg::WSUM_W + 1)'(in_set_mag);
  assign msum_add    = {1'b0, measured_sum} + (clp_pkg::MSUM_W + 1)'(in_meas_mag >> 3);

  // shared multiplier and divider operands
  assign mul_a       = lim_phase ? buffer_current_limit : mag;
  assign mul_b       = lim_phase ? clp_pkg::MAG_W'(eff_buffer) : current_limit;
  assign div_divisor = lim_phase ? clp_pkg::DVS_W'(warning_buffer) : wheel_abs_sum;

  // overload cut and sign
  always_comb begin
    if (over) begin
      cut_mag = k_wheel ? (mag >> 3) : (mag >> 1);
    end else begin
      cut_mag = mag;
    end
    signed_mag = neg ? (clp_pkg::MAG_W'(0) - cut_mag) : cut_mag;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      clp_pkg::ST_IDLE: begin
        if (motor_acc && s_tlast) begin
          state_next = clp_pkg::ST_LIMIT;
        end
      end
      clp_pkg::ST_LIMIT:    state_next = low_buffer ? clp_pkg::ST_MUL : clp_pkg::ST_FLAGS;
      clp_pkg::ST_MUL:      state_next = clp_pkg::ST_DIV_GO;
      clp_pkg::ST_DIV_GO:   state_next = clp_pkg::ST_DIV_WAIT;
      clp_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = lim_phase ? clp_pkg::ST_FLAGS : clp_pkg::ST_FIN;
        end
      end
      clp_pkg::ST_FLAGS:    state_next = clp_pkg::ST_RD;
      clp_pkg::ST_RD:       state_next = clp_pkg::ST_MAG;
      clp_pkg::ST_MAG:      state_next = (k_wheel && scaled) ? clp_pkg::ST_MUL : clp_pkg::ST_FIN;
      clp_pkg::ST_FIN:      state_next = clp_pkg::ST_OUT;
      clp_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = (k == W_IDX'(clp_pkg::NUM_MOTORS - 1)) ? clp_pkg::ST_IDLE
                                                              : clp_pkg::ST_RD;
        end
      end
      default: state_next = clp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready  = (state == clp_pkg::ST_IDLE);
    ram_re    = (state == clp_pkg::ST_RD);
    div_start = (state == clp_pkg::ST_DIV_GO);
    out_load  = (state == clp_pkg::ST_OUT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control and latched state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= clp_pkg::MODE_OFFLINE;
      buffer_reg    <= '0;
      wheel_abs_sum <= '0;
      measured_sum  <= '0;
      current_limit <= '0;
      lim_phase     <= 1'b0;
      k             <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (s_acc && (s_tuser == clp_pkg::KIND_REFEREE)) begin
        mode_reg   <= in_mode;
        buffer_reg <= in_buffer;
      end
      if (motor_acc) begin
        if (in_wheel) begin
          wheel_abs_sum <= wsum_add[clp_pkg::WSUM_W] ? clp_pkg::WSUM_MAX
                                                     : wsum_add[clp_pkg::WSUM_W-1:0];
        end
        measured_sum <= msum_add[clp_pkg::MSUM_W] ? clp_pkg::MSUM_MAX
                                                  : msum_add[clp_pkg::MSUM_W-1:0];
      end
      if (state == clp_pkg::ST_LIMIT) begin
        lim_phase <= low_buffer;
        if (!low_buffer) begin
          current_limit <= direct_limit;
        end
      end
      if ((state == clp_pkg::ST_DIV_WAIT) && div_stat.done && lim_phase) begin
        current_limit <= (div_q[clp_pkg::DVD_W-1:clp_pkg::LIM_W] != '0)
                         ? clp_pkg::LIM_MAX : div_q[clp_pkg::LIM_W-1:0];
      end
      if (state == clp_pkg::ST_FLAGS) begin
        lim_phase <= 1'b0;
        k         <= '0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        k        <= k + W_IDX'(1);
        if (k == W_IDX'(clp_pkg::NUM_MOTORS - 1)) begin
          wheel_abs_sum <= '0;
          measured_sum  <= '0;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == clp_pkg::ST_FLAGS) begin
      scaled <= wheel_abs_sum > {1'b0, current_limit};
      over   <= {2'b00, measured_sum} > overload_threshold;
    end
    if (state == clp_pkg::ST_MAG) begin
      mag <= clp_pkg::mag16(ram_rdata);
      neg <= ram_rdata[clp_pkg::SET_W-1];
    end
    if (state == clp_pkg::ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if ((state == clp_pkg::ST_DIV_WAIT) && div_stat.done && !lim_phase) begin
      mag <= div_q[clp_pkg::MAG_W-1:0];
    end
    if (state == clp_pkg::ST_FIN) begin
      res <= signed_mag[clp_pkg::SET_W-1:0];
    end
    if (out_load) begin
      m_tdata <= {5'b00000, res, k};
      m_tuser <= {over, scaled};
      m_tlast <= (k == W_IDX'(clp_pkg::NUM_MOTORS - 1));
    end
  end

  // setpoint store: writes only while idle, reads only while sequencing
  clp_ram #(
    .WIDTH (clp_pkg::SET_W),
    .DEPTH (clp_pkg::NUM_MOTORS)
  ) u_clp_ram (
    .clk   (clk),
    .we    (motor_acc),
    .waddr (in_index),
    .wdata (in_set),
    .re    (ram_re),
    .raddr (k),
    .rdata (ram_rdata)
  );

  clp_div u_clp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_divisor),
    .quotient (div_q),
    .stat     (div_stat)
  );

endmodule

>>> src/clp_checker.sv
// Port-level checker for the chassis current power limiter, with its bind
`include "chassis_current_power_limiter_assert.svh"

module clp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [clp_pkg::S_TDATA_W-1:0]     s_tdata,
  input logic                              s_tlast,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [clp_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic                              m_tlast,
  input logic [clp_pkg::M_TUSER_W-1:0]     m_tuser,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [clp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input logic [clp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  `CLP_ASSERT_NEXT(a_out_valid_held, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped")

  `CLP_ASSERT_NEXT(a_out_data_held, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed under stall")

  `CLP_ASSERT_IMPL(a_last_on_index7, m_tvalid, m_tlast == (m_tdata[2:0] == 3'd7), "m_tlast not on the eighth result")

  `CLP_ASSERT_AFTER_RESET(a_reset_empty, !m_tvalid && s_tready, "output not empty after reset")

endmodule

bind chassis_current_power_limiter clp_checker u_clp_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .s_tdata   (s_tdata),
  .s_tlast   (s_tlast),
  .s_tuser   (s_tuser),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .m_tuser   (m_tuser),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
